@@ hw/rtl/pts_pkg.sv @@
// shared constants and types for the periodic tick flag scheduler
`timescale 1ns / 1ps

package pts_pkg;

    localparam int SLOTS_DEFAULT = 4;
    localparam int TICK_W        = 32;
    localparam int PERIOD_W      = 16;
    localparam int ACTIVE_W      = 3;
    localparam int SLOT_IDX_W    = 2;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_SERVE = 1'b1
    } pts_cmd_t;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SLOTS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_SLOT0 = 3'd1;

    typedef struct packed {
        logic done;
        logic zero;
    } pts_mod_stat_t;

endpackage

@@ hw/rtl/pts_req_if.sv @@
// request channel: tick and serve items
`timescale 1ns / 1ps

interface pts_req_if
    import pts_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TICK_W-1:0] tick_value;

    modport source (output valid, output cmd, output tick_value, input ready);
    modport sink   (input valid, input cmd, input tick_value, output ready);
endinterface

@@ hw/rtl/pts_evt_if.sv @@
// event channel: channel indexes due for service
`timescale 1ns / 1ps

interface pts_evt_if
    import pts_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  last;

    modport source (output valid, output slot_index, output last, input ready);
    modport sink   (input valid, input slot_index, input last, output ready);
endinterface

@@ hw/rtl/pts_mod_unit.sv @@
// shared bit-serial remainder unit: tick value modulo a channel period
`timescale 1ns / 1ps

module pts_mod_unit
    import pts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TICK_W-1:0]   dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output pts_mod_stat_t       stat
);

    localparam int CNT_W = $clog2(TICK_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TICK_W-1:0]   dvd_reg;
    logic [PERIOD_W-1:0] dsr_reg;
    logic [PERIOD_W-1:0] rem_reg;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic [PERIOD_W-1:0] rem_next;

    // restoring step: shift in one dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[TICK_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = diff[PERIOD_W] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the final step
            done_reg <= busy_reg && (cnt_reg == '0);
            if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[TICK_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (start)
            begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(TICK_W - 1);
                busy_reg <= 1'b1;
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

@@ hw/rtl/periodic_tick_flag_scheduler.sv @@
// top level of the periodic tick flag scheduler
//
//   channel  role    handshake      payload
//   req      sink    valid/ready    cmd, tick_value
//   evt      source  valid/ready    slot_index, last
//   cfg      write   cfg_we         cfg_index, cfg_data
//
// a tick item runs the remainder unit once per active channel, one channel after
// another, on the 32-step remainder unit shared by all channels
// a serve item steps through the active channels in turn and holds while evt stalls
// req is ready only when the sequencer is idle; evt has its own output register
// reset clears the pending flags and active count, periods reset to one
`timescale 1ns / 1ps

module periodic_tick_flag_scheduler
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    pts_req_if.sink                req,
    pts_evt_if.source              evt,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK_START,
        ST_TICK_WAIT,
        ST_SERVE
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           idx_reg;
    logic [TICK_W-1:0]          tick_reg;
    logic [ACTIVE_W-1:0]        active_reg;
    logic [PERIOD_W-1:0]        period_reg [SLOTS];
    logic [SLOTS-1:0]           flags_reg;
    logic                       out_valid_reg;
    logic [SLOT_IDX_W-1:0]      out_idx_reg;
    logic                       out_last_reg;

    logic [CNT_W-1:0]           used_n;
    logic [IDX_W-1:0]           idx_sel;
    logic [PERIOD_W-1:0]        period_sel;
    logic                       more_pending;
    logic                       div_start;
    logic                       evt_load;
    pts_mod_stat_t              div_stat;

    always_comb
    begin
        used_n     = (active_reg > ACTIVE_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(active_reg);
        idx_sel    = idx_reg[IDX_W-1:0];
        period_sel = period_reg[idx_sel];
        div_start  = (state_reg == ST_TICK_START) && (idx_reg != used_n);
        // pending channel found and the output register free or draining
        evt_load   = (state_reg == ST_SERVE) && (idx_reg != used_n) && flags_reg[idx_sel]
                     && (!out_valid_reg || evt.ready);
    end

    // any active flag above the current channel decides the last mark
    always_comb
    begin
        more_pending = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if ((CNT_W'(j) > idx_reg) && (CNT_W'(j) < used_n) && flags_reg[j])
            begin
                more_pending = 1'b1;
            end
        end
    end

    pts_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tick_reg),
        .divisor  (period_sel),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                period_reg[j] <= PERIOD_W'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ACTIVE_SLOTS)
            begin
                active_reg <= cfg_data[ACTIVE_W-1:0];
            end
            for (int j = 0; j < SLOTS; j++)
            begin
                if (cfg_index == REG_PERIOD_SLOT0 + CFG_INDEX_W'(j))
                begin
                    period_reg[j] <= cfg_data[PERIOD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        tick_reg  <= req.tick_value;
                        idx_reg   <= '0;
                        state_reg <= (req.cmd == CMD_SERVE) ? ST_SERVE : ST_TICK_START;
                    end
                end
                ST_TICK_START:
                begin
                    state_reg <= (idx_reg == used_n) ? ST_IDLE : ST_TICK_WAIT;
                end
                ST_TICK_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        // a zero period never matches
                        if (div_stat.zero && (period_sel != '0))
                        begin
                            flags_reg[idx_sel] <= 1'b1;
                        end
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_TICK_START;
                    end
                end
                ST_SERVE:
                begin
                    if (idx_reg == used_n)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (!flags_reg[idx_sel])
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (evt_load)
                    begin
                        out_idx_reg        <= SLOT_IDX_W'(idx_sel);
                        out_last_reg       <= !more_pending;
                        flags_reg[idx_sel] <= 1'b0;
                        idx_reg            <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign evt.valid      = out_valid_reg;
    assign evt.slot_index = out_idx_reg;
    assign evt.last       = out_last_reg;

endmodule
